// ===== rtl/npd_pkg.sv =====
// Shared types and constants for the nearest point distance map.
`default_nettype none

package npd_pkg;

  localparam int unsigned CoordW  = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DistW   = 14;
  localparam int unsigned GridW   = 5;
  localparam int unsigned PointW  = 2 * CoordW;

  // squared distance: 2 * 15^2 = 450 fits 9 bits
  localparam int unsigned D2W   = 9;
  // square root working register and result widths
  localparam int unsigned ResW  = 10;
  localparam int unsigned RootW = 5;

  localparam logic [GridW-1:0] GridMax    = 5'd16;
  localparam logic [DistW-1:0] DistEmpty  = 14'd9999;
  localparam logic [D2W-1:0]   SqrtBitTop = 9'h100;

  typedef enum logic [CmdW-1:0] {
    CmdClear = 2'd0,
    CmdAdd   = 2'd1,
    CmdQuery = 2'd2
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StsOk      = 2'd0,
    StsFull    = 2'd1,
    StsOutside = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StRoot,
    StDone
  } state_e;

  // config register indexes
  typedef enum logic {
    RegGridSize = 1'b0
  } reg_e;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } point_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/npd_point_mem.sv =====
// Point store: one synchronous RAM holding both point sets.
`default_nettype none

module npd_point_mem #(
  parameter int unsigned AddrW = 5
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AddrW-1:0]   waddr_i,
  input  wire npd_pkg::point_t    wdata_i,
  input  wire logic               re_i,
  input  wire logic [AddrW-1:0]   raddr_i,
  output      npd_pkg::point_t    rdata_o
);
  import npd_pkg::*;

  localparam int unsigned Depth = 2 ** AddrW;

  point_t mem [Depth];
  point_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/npd_isqrt.sv =====
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module npd_isqrt (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [npd_pkg::D2W-1:0] value_i,
  output      npd_pkg::sqrt_rsp_t    rsp_o
);
  import npd_pkg::*;

  logic [D2W-1:0]  v_q, v_d;
  logic [ResW-1:0] res_q, res_d;
  logic [D2W-1:0]  bit_q, bit_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [ResW-1:0] trial;

  // trial subtrahend res + bit
  assign trial = res_q + ResW'(bit_q);

  always_comb begin
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d    = value_i;
      res_d  = '0;
      bit_d  = SqrtBitTop;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ResW'(v_q) >= trial) begin
        v_d   = v_q - D2W'(trial);
        res_d = (res_q >> 1) + ResW'(bit_q);
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == D2W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[RootW-1:0];

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("square root restarted while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("square root done without a run");
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q <= ResW'(21))
    else $error("square root result out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/nearest_point_distance_map.sv =====
// Top level of the nearest point distance map: control, scan and config port.
`default_nettype none

// Nearest point distance map. Two point sets (goals, task positions) share
// one RAM, MAX_POINTS entries each. An item clears a set, adds a point, or
// queries a cell; every item gives exactly one result item. Clear, add,
// unused commands, off-grid coordinates and queries of an empty set are
// answered without a scan. A query of a set holding n points reads the RAM
// one point per cycle (one read port), squares and compares in a two-stage
// pipeline, then runs a 5-step iterative square root. One item is processed
// at a time; input is stalled during a query and while a finished result
// waits stalled at the output. grid_size sits at byte address 0 of the APB
// port and resets to 16; points stored before grid_size shrinks stay in
// their set. The RAM needs no clearing: only entries below a set's count
// are ever read.
module nearest_point_distance_map #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // item input
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [npd_pkg::CmdW-1:0]    command_i,
  input  wire logic                        point_set_i,
  input  wire logic [npd_pkg::CoordW-1:0]  row_i,
  input  wire logic [npd_pkg::CoordW-1:0]  column_i,
  // result output
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [npd_pkg::StatusW-1:0] status_o,
  output      logic [npd_pkg::DistW-1:0]   distance_o,
  // config port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);
  import npd_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned IdxW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned AddrW = IdxW + 1;
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_POINTS);

  // ---------------- config register ----------------
  logic [GridW-1:0] grid_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GridMax;
    end else if (cfg_wr && (paddr[2] == RegGridSize)) begin
      grid_q <= pwdata[GridW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegGridSize) ? 32'(grid_q) : '0;

  // ---------------- control state ----------------
  state_e            state_q, state_d;
  logic [CntW-1:0]   goal_cnt_q, task_cnt_q;
  logic              set_q;
  logic [CoordW-1:0] row_q, col_q;
  logic [CntW-1:0]   rd_idx_q;
  logic              rd_vld_q, d2_vld_q;
  logic [D2W-1:0]    d2_q, best_q;
  logic              out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [DistW-1:0]  dist_q;

  logic              in_acc;
  logic              out_free;
  logic              on_grid;
  logic [CntW-1:0]   in_cnt;   // count of the set named by the input item
  logic [CntW-1:0]   scan_cnt; // count of the set under query
  logic              go_scan;
  logic              scan_done;
  logic              rd_en;
  logic              sqrt_start;
  logic              load_done;
  logic              wr_en;
  logic              imm_load;
  status_e           imm_status;
  logic [DistW-1:0]  imm_dist;
  point_t            rd_point;
  sqrt_rsp_t         sqrt_rsp;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign on_grid  = ({1'b0, row_i} < grid_q) && ({1'b0, column_i} < grid_q);
  assign in_cnt   = point_set_i ? task_cnt_q : goal_cnt_q;
  assign scan_cnt = set_q ? task_cnt_q : goal_cnt_q;

  // immediate decode of the accepted item
  always_comb begin
    imm_status = StsOk;
    imm_dist   = '0;
    wr_en      = 1'b0;
    go_scan    = 1'b0;
    case (cmd_e'(command_i))
      CmdClear: begin
      end
      CmdAdd: begin
        if (!on_grid) begin
          imm_status = StsOutside;
        end else if (in_cnt == CntFull) begin
          imm_status = StsFull;
        end else begin
          wr_en = in_acc;
        end
      end
      CmdQuery: begin
        if (!on_grid) begin
          imm_status = StsOutside;
        end else if (in_cnt == '0) begin
          imm_dist = DistEmpty;
        end else begin
          go_scan = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign imm_load  = in_acc && !go_scan;
  assign scan_done = (rd_idx_q == scan_cnt) && !rd_vld_q && !d2_vld_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && go_scan) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (scan_done) begin
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (sqrt_rsp.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    sqrt_start = 1'b0;
    load_done  = 1'b0;
    case (state_q)
      StIdle: in_stall_o = !out_free;
      StScan: begin
        rd_en      = (rd_idx_q != scan_cnt);
        sqrt_start = scan_done;
      end
      StRoot: begin
      end
      StDone: load_done = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      goal_cnt_q  <= '0;
      task_cnt_q  <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      d2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      d2_vld_q <= rd_vld_q;
      if (in_acc) begin
        rd_idx_q <= '0;
      end else if (rd_en) begin
        rd_idx_q <= rd_idx_q + CntW'(1);
      end
      if (in_acc && (cmd_e'(command_i) == CmdClear)) begin
        if (point_set_i) begin
          task_cnt_q <= '0;
        end else begin
          goal_cnt_q <= '0;
        end
      end else if (wr_en) begin
        if (point_set_i) begin
          task_cnt_q <= task_cnt_q + CntW'(1);
        end else begin
          goal_cnt_q <= goal_cnt_q + CntW'(1);
        end
      end
      if (imm_load || load_done) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      set_q  <= point_set_i;
      row_q  <= row_i;
      col_q  <= column_i;
      best_q <= '1;
    end else if (d2_vld_q && (d2_q < best_q)) begin
      best_q <= d2_q;
    end
    if (imm_load) begin
      status_q <= imm_status;
      dist_q   <= imm_dist;
    end else if (load_done) begin
      status_q <= StsOk;
      dist_q   <= DistW'(sqrt_rsp.root);
    end
  end

  // ---------------- scan datapath ----------------
  // Writes happen only at accept, reads only during a later query scan,
  // so the RAM never sees a read and write of one entry in flight.
  npd_point_mem #(
    .AddrW(AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i ({point_set_i, in_cnt[IdxW-1:0]}),
    .wdata_i ({row_i, column_i}),
    .re_i    (rd_en),
    .raddr_i ({set_q, rd_idx_q[IdxW-1:0]}),
    .rdata_o (rd_point)
  );

  logic [CoordW-1:0] dr, dc;
  logic [D2W-1:0]    dr_w, dc_w;

  assign dr = (row_q > rd_point.row) ? row_q - rd_point.row : rd_point.row - row_q;
  assign dc = (col_q > rd_point.col) ? col_q - rd_point.col : rd_point.col - col_q;
  // widen before squaring so the products keep all their bits
  assign dr_w = D2W'(dr);
  assign dc_w = D2W'(dc);

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      d2_q <= dr_w * dr_w + dc_w * dc_w;
    end
  end

  npd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (best_q),
    .rsp_o   (sqrt_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign distance_o  = dist_q;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (goal_cnt_q <= CntFull) && (task_cnt_q <= CntFull))
    else $error("point count above store depth");
  a_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (!rd_vld_q && !d2_vld_q))
    else $error("scan pipeline busy outside a query");
  a_root_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_rsp.done |-> (state_q == StRoot))
    else $error("square root finished outside root state");
  a_scan_cnt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) && $past(state_q == StScan) |-> $stable(scan_cnt))
    else $error("set count changed during a scan");
`endif

endmodule

`default_nettype wire
